>>> rtl/core/ece_pkg.sv
package ece_pkg;

  // probability format
  localparam int PROB_FRAC_BITS = 16;
  localparam int PROB_W         = PROB_FRAC_BITS + 1;
  localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

  // log table geometry
  localparam int LOG_TABLE_DEPTH = 256;
  localparam int LOG_IDX_W       = $clog2(LOG_TABLE_DEPTH);
  localparam int LOG_ADDR_W      = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int LOG_VAL_W       = 24;

  // datapath widths
  localparam int H_W        = $clog2(PROB_W);
  localparam int POS_W      = PROB_W + LOG_IDX_W;
  localparam int IPROD_W    = LOG_VAL_W + PROB_FRAC_BITS;
  localparam int NL_W       = LOG_VAL_W + H_W;
  localparam int TPROD_W    = PROB_W + NL_W;
  localparam int TERM_SHIFT = PROB_FRAC_BITS + 8;
  localparam int TERM_W     = TPROD_W - TERM_SHIFT;
  localparam int SUM_W      = 32;
  localparam int OUT_W      = 24;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] OUT_MAX = {{(SUM_W-OUT_W){1'b0}}, {OUT_W{1'b1}}};

  // series precision used to build the table
  localparam int SER_BITS = 30;

  typedef struct packed {
    logic [PROB_W-1:0] q_value;
    logic [PROB_W-1:0] p_value;
    logic              last_row;
  } row_t;

  typedef struct packed {
    logic [OUT_W-1:0] neg_entropy;
    logic [OUT_W-1:0] neg_cross_entropy;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic norm;
    logic read;
    logic log_step;
    logic mul;
    logic acc;
    logic emit;
    logic sel_p;
  } ece_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic q_zero;
    logic p_zero;
    logic last;
    logic out_free;
  } ece_stat_t;

  typedef logic [LOG_VAL_W-1:0] log_rom_t [LOG_TABLE_DEPTH+1];

  // shift-subtract division, elaboration only
  function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ln(1 + i/D) in Q0.24 through 2*atanh(i/(2D+i)), series in Q2.30
  function automatic logic [LOG_VAL_W-1:0] log_entry(input logic [63:0] i);
    logic [63:0] den;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] pw;
    logic [63:0] sum;
    logic [63:0] res;
    den = 64'(2 * LOG_TABLE_DEPTH) + i;
    z   = const_div((i << SER_BITS) + (den >> 1), den);
    z2  = (z * z) >> SER_BITS;
    pw  = z;
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      if (pw != '0) begin
        sum = sum + const_div(pw, 64'(2 * k + 1));
        pw  = (pw * z2) >> SER_BITS;
      end
    end
    res = ((sum << 1) + 64'd32) >> (SER_BITS - LOG_VAL_W);
    return res[LOG_VAL_W-1:0];
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
      rom[i] = log_entry(64'(i));
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

>>> rtl/core/ece_ctrl.sv
module ece_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               row_valid,
  output logic               row_stall,
  input  ece_pkg::ece_stat_t stat,
  output ece_pkg::ece_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DISPATCH = 8'b0000_0010,
    ST_NORM     = 8'b0000_0100,
    ST_READ     = 8'b0000_1000,
    ST_LOG      = 8'b0001_0000,
    ST_MUL      = 8'b0010_0000,
    ST_ACC      = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   sel_p;
  logic   sel_p_next;

  // rows are taken only between transactions
  assign row_stall = (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel_p <= 1'b0;
    end else begin
      state <= state_next;
      sel_p <= sel_p_next;
    end
  end

  // sequencing of the two log terms and the result
  always_comb begin
    state_next   = state;
    sel_p_next   = sel_p;
    cmd          = '0;
    cmd.sel_p    = sel_p;
    unique case (state)
      ST_IDLE: begin
        cmd.load = row_valid;
        if (row_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        sel_p_next = 1'b0;
        if (stat.q_zero) begin
          state_next = stat.last ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.norm   = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_LOG;
      end
      ST_LOG: begin
        cmd.log_step = 1'b1;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (!sel_p && !stat.p_zero) begin
          sel_p_next = 1'b1;
          state_next = ST_NORM;
        end else begin
          state_next = stat.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/ece_dp.sv
module ece_dp (
  input  logic               clk,
  input  logic               rst,
  input  ece_pkg::row_t      row,
  output logic               result_valid,
  input  logic               result_stall,
  output ece_pkg::result_t   result,
  input  ece_pkg::ece_cmd_t  cmd,
  output ece_pkg::ece_stat_t stat
);

  logic [ece_pkg::PROB_W-1:0]     q_reg;
  logic [ece_pkg::PROB_W-1:0]     p_reg;
  logic                           last_reg;
  logic [ece_pkg::H_W-1:0]        h_reg;
  logic [ece_pkg::LOG_IDX_W-1:0]  idx_reg;
  logic [ece_pkg::PROB_FRAC_BITS-1:0] rem_reg;
  logic [ece_pkg::LOG_VAL_W-1:0]  lo_reg;
  logic [ece_pkg::IPROD_W-1:0]    iprod_reg;
  logic [ece_pkg::NL_W-1:0]       nl_reg;
  logic [ece_pkg::TPROD_W-1:0]    tprod_reg;
  logic [ece_pkg::SUM_W-1:0]      entropy_sum;
  logic [ece_pkg::SUM_W-1:0]      cross_sum;

  logic [ece_pkg::PROB_W-1:0]     x_sel;
  logic [ece_pkg::H_W-1:0]        lead;
  logic [ece_pkg::PROB_W-1:0]     frac;
  logic [ece_pkg::POS_W-1:0]      pos;
  logic [ece_pkg::POS_W-1:0]      pos_shr;
  logic [ece_pkg::POS_W-1:0]      rem_full;
  logic [ece_pkg::LOG_VAL_W-1:0]  lo_val;
  logic [ece_pkg::LOG_VAL_W-1:0]  hi_val;
  logic [ece_pkg::LOG_VAL_W-1:0]  diff;
  logic [ece_pkg::IPROD_W-1:0]    interp;
  logic [ece_pkg::LOG_VAL_W-1:0]  lnm;
  logic [ece_pkg::H_W-1:0]        scale;
  logic [ece_pkg::NL_W-1:0]       nl_calc;
  logic [ece_pkg::TPROD_W-1:0]    rounded;
  logic [ece_pkg::TERM_W-1:0]     term;
  logic [ece_pkg::SUM_W-1:0]      acc_in;
  logic [ece_pkg::SUM_W:0]        acc_sum;
  logic [ece_pkg::SUM_W-1:0]      acc_sat;

  // leading one and table position of the selected probability
  always_comb begin
    x_sel = cmd.sel_p ? p_reg : q_reg;
    lead  = '0;
    for (int b = 0; b < ece_pkg::PROB_W; b++) begin
      if (x_sel[b]) begin
        lead = ece_pkg::H_W'(b);
      end
    end
    frac     = x_sel & ~(ece_pkg::PROB_W'(1) << lead);
    pos      = {frac, {ece_pkg::LOG_IDX_W{1'b0}}};
    pos_shr  = pos >> lead;
    rem_full = pos & ((ece_pkg::POS_W'(1) << lead) - ece_pkg::POS_W'(1));
  end

  // table read and interpolation step
  always_comb begin
    lo_val = ece_pkg::LOG_ROM[{1'b0, idx_reg}];
    hi_val = ece_pkg::LOG_ROM[{1'b0, idx_reg} + ece_pkg::LOG_ADDR_W'(1)];
    diff   = hi_val - lo_val;
  end

  // minus ln as exponent times ln 2 less ln of the mantissa
  always_comb begin
    interp  = iprod_reg >> h_reg;
    lnm     = lo_reg + interp[ece_pkg::LOG_VAL_W-1:0];
    scale   = ece_pkg::H_W'(ece_pkg::PROB_FRAC_BITS) - h_reg;
    nl_calc = ece_pkg::NL_W'(scale) * ece_pkg::NL_W'(ece_pkg::LOG_ROM[ece_pkg::LOG_TABLE_DEPTH])
              - ece_pkg::NL_W'(lnm);
  end

  // rounded term and saturating accumulate
  always_comb begin
    rounded = tprod_reg + (ece_pkg::TPROD_W'(1) << (ece_pkg::TERM_SHIFT - 1));
    term    = rounded[ece_pkg::TPROD_W-1:ece_pkg::TERM_SHIFT];
    acc_in  = cmd.sel_p ? cross_sum : entropy_sum;
    acc_sum = {1'b0, acc_in} + (ece_pkg::SUM_W+1)'(term);
    acc_sat = acc_sum[ece_pkg::SUM_W] ? ece_pkg::SUM_MAX : acc_sum[ece_pkg::SUM_W-1:0];
  end

  // payload registers of the log pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_reg    <= (row.q_value > ece_pkg::PROB_ONE) ? ece_pkg::PROB_ONE : row.q_value;
      p_reg    <= (row.p_value > ece_pkg::PROB_ONE) ? ece_pkg::PROB_ONE : row.p_value;
      last_reg <= row.last_row;
    end
    if (cmd.norm) begin
      h_reg   <= lead;
      idx_reg <= pos_shr[ece_pkg::LOG_IDX_W-1:0];
      rem_reg <= rem_full[ece_pkg::PROB_FRAC_BITS-1:0];
    end
    if (cmd.read) begin
      lo_reg    <= lo_val;
      iprod_reg <= ece_pkg::IPROD_W'(diff) * ece_pkg::IPROD_W'(rem_reg);
    end
    if (cmd.log_step) begin
      nl_reg <= nl_calc;
    end
    if (cmd.mul) begin
      tprod_reg <= ece_pkg::TPROD_W'(q_reg) * ece_pkg::TPROD_W'(nl_reg);
    end
    if (cmd.emit) begin
      result.neg_entropy       <= (entropy_sum > ece_pkg::OUT_MAX) ?
                                  ece_pkg::OUT_MAX[ece_pkg::OUT_W-1:0] :
                                  entropy_sum[ece_pkg::OUT_W-1:0];
      result.neg_cross_entropy <= (cross_sum > ece_pkg::OUT_MAX) ?
                                  ece_pkg::OUT_MAX[ece_pkg::OUT_W-1:0] :
                                  cross_sum[ece_pkg::OUT_W-1:0];
    end
  end

  // running sums and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      entropy_sum  <= '0;
      cross_sum    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        entropy_sum  <= '0;
        cross_sum    <= '0;
        result_valid <= 1'b1;
      end else begin
        if (cmd.acc) begin
          if (cmd.sel_p) begin
            cross_sum <= acc_sat;
          end else begin
            entropy_sum <= acc_sat;
          end
        end
        if (result_valid && !result_stall) begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  // status back to the controller
  assign stat.q_zero   = (q_reg == '0);
  assign stat.p_zero   = (p_reg == '0);
  assign stat.last     = last_reg;
  assign stat.out_free = !result_valid || !result_stall;

endmodule

>>> rtl/core/entropy_cross_entropy_accumulator.sv
// channel  direction  handshake                   payload
// row      in         row_valid / row_stall       row    (q_value, p_value, last_row)
// result   out        result_valid / result_stall result (neg_entropy, neg_cross_entropy)
//
// one row at a time: a row whose q is zero skips the log unit; otherwise the
// entropy term and, unless p is zero, the cross-entropy term run in turn
// through the shared log unit (NORM, READ, LOG, MUL, ACC); a last row then
// loads the result register in EMIT, waiting while the previous result stalls
// rst is synchronous and clears the controller, both sums and result_valid
// a waiting result does not block the next row

module entropy_cross_entropy_accumulator (
  input  logic             clk,
  input  logic             rst,
  input  logic             row_valid,
  output logic             row_stall,
  input  ece_pkg::row_t    row,
  output logic             result_valid,
  input  logic             result_stall,
  output ece_pkg::result_t result
);

  ece_pkg::ece_cmd_t  cmd;
  ece_pkg::ece_stat_t stat;

  // sequencer
  ece_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // log unit, sums and result register
  ece_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .row          (row),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
